// File: sv/at_response_line_parser_macros.svh
// assertion macros used by the line parser top module
`ifndef AT_RESPONSE_LINE_PARSER_MACROS_SVH
`define AT_RESPONSE_LINE_PARSER_MACROS_SVH

// same-cycle implication, checked out of reset
`define ATRLP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line parser check failed");

// next-cycle implication, checked out of reset
`define ATRLP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line parser check failed");

`endif

// File: sv/atrlp_pkg.sv
// types, character codes and pattern tables for the modem response line parser
`default_nettype none

package atrlp_pkg;

  // character codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // line kinds
  localparam logic [1:0] KIND_OTHER  = 2'd0;
  localparam logic [1:0] KIND_OK     = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;
  localparam logic [1:0] KIND_RING   = 2'd3;

  // prefix candidate bits
  localparam int unsigned PF_OK   = 0;
  localparam int unsigned PF_IX   = 1;
  localparam int unsigned PF_RING = 2;
  localparam logic [2:0]  PF_ALL  = 3'b111;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  // report field indexes
  localparam logic [2:0] FI_MO     = 3'd0;
  localparam logic [2:0] FI_SKIP_A = 3'd1;
  localparam logic [2:0] FI_MT     = 3'd2;
  localparam logic [2:0] FI_SKIP_B = 3'd3;
  localparam logic [2:0] FI_LEN    = 3'd4;
  localparam logic [2:0] FI_QUEUED = 3'd5;
  localparam logic [2:0] FI_DONE   = 3'd6;

  // control from the framer to the report parser
  typedef struct packed {
    logic       clear;
    logic       feed;
    logic       feed_break;
    logic       line_end;
    logic [1:0] kind;
  } atrlp_ctrl_t;

  // values of one result apart from the kind
  typedef struct packed {
    logic        parse_ok;
    logic [15:0] mo_status;
    logic [15:0] mt_status;
    logic [15:0] mt_length;
    logic [15:0] mt_queued;
    logic        message_waiting;
    logic [15:0] receive_count;
    logic        mo_success;
  } atrlp_rsp_t;

  function automatic logic [7:0] pat_ok_char(input logic idx);
    logic [7:0] ch;
    unique case (idx)
      1'b0:    ch = 8'h4F;
      default: ch = 8'h4B;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] pat_ix_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h2B;
      3'd1:    ch = 8'h53;
      3'd2:    ch = 8'h42;
      3'd3:    ch = 8'h44;
      3'd4:    ch = 8'h49;
      3'd5:    ch = 8'h58;
      3'd6:    ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] pat_ring_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h53;
      3'd1:    ch = 8'h42;
      3'd2:    ch = 8'h44;
      3'd3:    ch = 8'h52;
      3'd4:    ch = 8'h49;
      3'd5:    ch = 8'h4E;
      3'd6:    ch = 8'h47;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: sv/atrlp_line.sv
// line framer: position, break tracking and prefix classification
`default_nettype none

module atrlp_line #(
  parameter int unsigned LINE_MAX = 99
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic [7:0]          rx_byte,
  output logic                     ends,
  output atrlp_pkg::atrlp_ctrl_t   ctrl
);
  import atrlp_pkg::*;

  localparam int unsigned PW = $clog2(LINE_MAX + 1);

  logic [PW-1:0] pos_r, pos_nxt;
  logic          pending_cr_r, pending_cr_nxt;
  logic          trailing_break_r, trailing_break_nxt;
  logic [2:0]    prefix_r, prefix_nxt;

  logic          brk;
  logic          restart;
  logic [PW-1:0] pos_eff;
  logic          pend_eff;
  logic          trail_eff;
  logic [2:0]    prefix_eff;
  logic [2:0]    prefix_upd;
  logic          drop;
  logic          line_end_raw;
  logic [1:0]    kind;

  // per-word framing and prefix match
  always_comb begin
    brk        = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    restart    = pos_r >= PW'(LINE_MAX);
    pos_eff    = restart ? '0 : pos_r;
    pend_eff   = restart ? 1'b0 : pending_cr_r;
    trail_eff  = restart ? 1'b0 : trailing_break_r;
    prefix_eff = restart ? PF_ALL : prefix_r;
    drop       = (pos_eff == '0) && brk;

    prefix_upd = prefix_eff;
    if (pos_eff < PW'(2) && rx_byte != pat_ok_char(pos_eff[0])) begin
      prefix_upd[PF_OK] = 1'b0;
    end
    if (pos_eff < PW'(7)) begin
      if (rx_byte != pat_ix_char(pos_eff[2:0])) begin
        prefix_upd[PF_IX] = 1'b0;
      end
      if (rx_byte != pat_ring_char(pos_eff[2:0])) begin
        prefix_upd[PF_RING] = 1'b0;
      end
    end else if (!brk) begin
      prefix_upd[PF_RING] = 1'b0;
    end

    line_end_raw = !drop && (rx_byte == CH_LF) && pend_eff;
    ends         = line_end_raw;

    if (prefix_upd[PF_OK]) begin
      kind = KIND_OK;
    end else if (prefix_upd[PF_IX]) begin
      kind = KIND_REPORT;
    end else if (prefix_upd[PF_RING]) begin
      kind = KIND_RING;
    end else begin
      kind = KIND_OTHER;
    end

    pos_nxt            = pos_r;
    pending_cr_nxt     = pending_cr_r;
    trailing_break_nxt = trailing_break_r;
    prefix_nxt         = prefix_r;
    if (step) begin
      if (drop) begin
        pos_nxt            = pos_eff;
        pending_cr_nxt     = pend_eff;
        trailing_break_nxt = trail_eff;
        prefix_nxt         = prefix_eff;
      end else if (line_end_raw) begin
        pos_nxt            = '0;
        pending_cr_nxt     = 1'b0;
        trailing_break_nxt = 1'b0;
        prefix_nxt         = PF_ALL;
      end else begin
        pos_nxt            = pos_eff + PW'(1);
        pending_cr_nxt     = rx_byte == CH_CR;
        trailing_break_nxt = brk;
        prefix_nxt         = prefix_upd;
      end
    end

    ctrl.clear      = step && (restart || line_end_raw);
    ctrl.feed       = step && !drop && (pos_eff >= PW'(7)) && !brk && prefix_eff[PF_IX];
    ctrl.feed_break = trail_eff;
    ctrl.line_end   = step && line_end_raw;
    ctrl.kind       = kind;
  end

  // framing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r            <= '0;
      pending_cr_r     <= 1'b0;
      trailing_break_r <= 1'b0;
      prefix_r         <= PF_ALL;
    end else begin
      pos_r            <= pos_nxt;
      pending_cr_r     <= pending_cr_nxt;
      trailing_break_r <= trailing_break_nxt;
      prefix_r         <= prefix_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/atrlp_report.sv
// report field parser: decimal fields, captures and receive queue
`default_nettype none

module atrlp_report (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [7:0]            rx_byte,
  input  wire atrlp_pkg::atrlp_ctrl_t ctrl,
  output atrlp_pkg::atrlp_rsp_t      rsp
);
  import atrlp_pkg::*;

  logic [2:0]  fi_r, fi_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic        phase_r, phase_nxt;
  logic        malformed_r, malformed_nxt;
  logic [15:0] cap_r [4];
  logic [15:0] cap_nxt [4];
  logic [15:0] queue_r, queue_nxt;
  logic        waiting_r, waiting_nxt;

  logic        mal_pre;
  logic        is_digit;
  logic [19:0] acc_mul;
  logic [15:0] acc_sat;
  logic        slot_hit;
  logic [1:0]  slot;
  logic        ok;
  logic [15:0] f_queued;

  // field parse and line-end result
  always_comb begin
    is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    acc_mul  = {4'd0, acc_r} * 20'd10 + {16'd0, rx_byte[3:0]};
    acc_sat  = (|acc_mul[19:16]) ? SAT16 : acc_mul[15:0];

    slot_hit = 1'b1;
    case (fi_r)
      FI_MO:     slot = 2'd0;
      FI_MT:     slot = 2'd1;
      FI_LEN:    slot = 2'd2;
      FI_QUEUED: slot = 2'd3;
      default: begin
        slot     = 2'd0;
        slot_hit = 1'b0;
      end
    endcase

    fi_nxt        = fi_r;
    acc_nxt       = acc_r;
    phase_nxt     = phase_r;
    malformed_nxt = malformed_r;
    for (int i = 0; i < 4; i++) begin
      cap_nxt[i] = cap_r[i];
    end
    queue_nxt   = queue_r;
    waiting_nxt = waiting_r;

    // a line break inside the report breaks any numeric field
    mal_pre = malformed_r;
    if (ctrl.feed_break && !malformed_r && fi_r < FI_DONE &&
        fi_r != FI_SKIP_A && fi_r != FI_SKIP_B) begin
      mal_pre = 1'b1;
    end

    // one character into the field parser
    if (ctrl.feed) begin
      malformed_nxt = mal_pre;
      if (!mal_pre && fi_r < FI_DONE) begin
        if (fi_r == FI_SKIP_A || fi_r == FI_SKIP_B) begin
          if (rx_byte == CH_COMMA) begin
            fi_nxt    = fi_r + 3'd1;
            phase_nxt = 1'b0;
          end
        end else if (!phase_r) begin
          if (is_digit) begin
            acc_nxt   = {12'd0, rx_byte[3:0]};
            phase_nxt = 1'b1;
          end else if (rx_byte != CH_SPACE) begin
            malformed_nxt = 1'b1;
          end
        end else if (is_digit) begin
          acc_nxt = acc_sat;
        end else if (rx_byte == CH_COMMA) begin
          if (slot_hit) begin
            cap_nxt[slot] = acc_r;
          end
          fi_nxt    = fi_r + 3'd1;
          phase_nxt = 1'b0;
          acc_nxt   = '0;
        end else begin
          malformed_nxt = 1'b1;
        end
      end
    end

    // result of a finished line
    ok = ctrl.line_end && (ctrl.kind == KIND_REPORT) && !malformed_r &&
         ((fi_r == FI_QUEUED && phase_r) || fi_r >= FI_DONE);
    f_queued = (fi_r == FI_QUEUED) ? acc_r : cap_r[3];
    if (ok) begin
      if (fi_r == FI_QUEUED) begin
        cap_nxt[3] = acc_r;
      end
      waiting_nxt = cap_r[1] == 16'd1;
      if (cap_r[1] == 16'd1) begin
        queue_nxt = (f_queued == SAT16) ? SAT16 : f_queued + 16'd1;
      end
    end

    if (ctrl.clear) begin
      fi_nxt        = FI_MO;
      acc_nxt       = '0;
      phase_nxt     = 1'b0;
      malformed_nxt = 1'b0;
    end

    rsp.parse_ok        = ok;
    rsp.mo_status       = ok ? cap_r[0] : 16'd0;
    rsp.mt_status       = ok ? cap_r[1] : 16'd0;
    rsp.mt_length       = ok ? cap_r[2] : 16'd0;
    rsp.mt_queued       = ok ? f_queued : 16'd0;
    rsp.message_waiting = waiting_nxt;
    rsp.receive_count   = queue_nxt;
    rsp.mo_success      = ok && (cap_r[0] <= 16'd4);
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fi_r        <= FI_MO;
      acc_r       <= '0;
      phase_r     <= 1'b0;
      malformed_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        cap_r[i] <= '0;
      end
      queue_r     <= '0;
      waiting_r   <= 1'b0;
    end else begin
      fi_r        <= fi_nxt;
      acc_r       <= acc_nxt;
      phase_r     <= phase_nxt;
      malformed_r <= malformed_nxt;
      for (int i = 0; i < 4; i++) begin
        cap_r[i] <= cap_nxt[i];
      end
      queue_r     <= queue_nxt;
      waiting_r   <= waiting_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/at_response_line_parser.sv
// result: the result register is loaded when the held line-feed word that ends its line moves on
// throughput: one received word per cycle; a line-feed word that ends a line waits only
// while an earlier result word is still held unaccepted in the result register
// reset: synchronous active-low rst_n clears the framer, the field parser, the
// receive queue and both valid flags; no clearing pass is needed
`default_nettype none

module at_response_line_parser #(
  parameter int unsigned LINE_MAX = 99
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata   // [1:0] line_kind, [2] parse_ok, [18:3] mo_status,
                                       // [34:19] mt_status, [50:35] mt_length,
                                       // [66:51] mt_queued, [67] message_waiting,
                                       // [83:68] receive_count, [84] mo_success, [87:85] zero
);
  import atrlp_pkg::*;

  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  in_byte_r;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r;
  atrlp_rsp_t  rsp_r;

  logic        out_free;
  logic        ends;
  logic        process;
  atrlp_ctrl_t ctrl;
  atrlp_rsp_t  rsp;

  // a held word moves on unless it ends a line and the result register is full and not being accepted
  always_comb begin
    out_free      = !out_valid_r || out_tready;
    process       = in_valid_r && (!ends || out_free);
    in_tready     = !in_valid_r || process;
    in_valid_nxt  = (in_tvalid && in_tready) || (in_valid_r && !process);
    out_valid_nxt = (process && ends) || (out_valid_r && !out_tready);
  end

  atrlp_line #(
    .LINE_MAX (LINE_MAX)
  ) u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (process),
    .rx_byte (in_byte_r),
    .ends    (ends),
    .ctrl    (ctrl)
  );

  atrlp_report u_report (
    .clk     (clk),
    .rst_n   (rst_n),
    .rx_byte (in_byte_r),
    .ctrl    (ctrl),
    .rsp     (rsp)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input and result payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (process && ends) begin
      kind_r <= ctrl.kind;
      rsp_r  <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, rsp_r.mo_success, rsp_r.receive_count, rsp_r.message_waiting,
                       rsp_r.mt_queued, rsp_r.mt_length, rsp_r.mt_status, rsp_r.mo_status,
                       rsp_r.parse_ok, kind_r};

`include "at_response_line_parser_macros.svh"

  // a result is only loaded when the result register can take it
  `ATRLP_ASSERT_IMPL(a_no_overwrite, process && ends, out_free)
  // a good parse only comes from a report line
  `ATRLP_ASSERT_IMPL(a_ok_is_report, out_valid_r && rsp_r.parse_ok, kind_r == KIND_REPORT)
  // success needs a good parse
  `ATRLP_ASSERT_IMPL(a_success_needs_ok, out_valid_r && rsp_r.mo_success, rsp_r.parse_ok)
  // a held word that does not end a line never waits
  `ATRLP_ASSERT_IMPL(a_word_moves, in_valid_r && !ends, in_tready)

endmodule

`default_nettype wire
